FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/rshs_pkg.sv
// Package: widths, register indexes and types of the sample-and-hold block.
package rshs_pkg;

  localparam int RAW_W      = 24;
  localparam int CV_W       = 17;
  localparam int BEAT_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 32;
  localparam int MODE_W     = 4;
  localparam int SCALED_W   = 20;
  localparam int PHASE_W    = 33;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_STEPS       = FRAC_W;
  localparam int MODE_MAX        = 9;
  localparam int SYNC_SHIFT_BASE = 22;
  localparam int PULSE_SAMPLES_DEFAULT = 48;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CV_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CV_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_COEF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_MODE = 3'd7;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic [CV_W-1:0]         cv_t;
  typedef logic [FRAC_W-1:0]       frac_t;
  typedef logic [BEAT_W-1:0]       beat_t;

endpackage

FILE: rtl/rshs_if.sv
// Channel interfaces: sample tick words in, result words out.
interface rshs_in_if;
  import rshs_pkg::*;
  logic  valid;
  logic  ready;
  logic  transport_playing;
  beat_t beat_position;
  frac_t random_raw;
  frac_t random_cv;

  modport source (output valid, transport_playing, beat_position, random_raw, random_cv,
                  input ready);
  modport sink (input valid, transport_playing, beat_position, random_raw, random_cv,
                output ready);
endinterface

interface rshs_out_if;
  import rshs_pkg::*;
  logic valid;
  logic ready;
  raw_t raw_value;
  cv_t  cv_value;
  logic gate;
  logic trigger;

  modport source (output valid, raw_value, cv_value, gate, trigger, input ready);
  modport sink (input valid, raw_value, cv_value, gate, trigger, output ready);
endinterface

FILE: rtl/rshs_serial_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
module rshs_serial_mul #(
  parameter int W = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [W-1:0]          mcand,
  input  logic [rshs_pkg::FRAC_W-1:0]  mplier,
  output logic                         done,
  output logic signed [W:0]            prod_hi,
  output logic                         prod_rnd
);
  import rshs_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic signed [W-1:0] mcand_q;
  logic [FRAC_W-1:0]   mplier_sr;
  logic                run;
  logic [CNT_W-1:0]    cnt;
  logic signed [W:0]   hi;
  logic                rnd;
  logic signed [W+1:0] addend;
  logic signed [W+1:0] sum;

  // Add the multiplicand for a set bit, then halve; the shifted-out bit is kept.
  always_comb begin
    addend = mplier_sr[0] ? {{2{mcand_q[W-1]}}, mcand_q} : '0;
    sum    = {hi[W], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_q   <= mcand;
      mplier_sr <= mplier;
      hi        <= '0;
      rnd       <= 1'b0;
    end else if (run) begin
      mplier_sr <= mplier_sr >> 1;
      hi        <= sum[W+1:1];
      rnd       <= sum[0];
    end
  end

  // After the last step hi is the product floored by 2^16, rnd its bit 15.
  assign prod_hi  = hi;
  assign prod_rnd = rnd;

endmodule

FILE: rtl/rshs_event.sv
// Draw event detection: free-running phase wrap or rising scaled beat.
module rshs_event (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         transport_playing,
  input  logic [rshs_pkg::BEAT_W-1:0]  beat_position,
  input  logic [rshs_pkg::STEP_W-1:0]  phase_step,
  input  logic [rshs_pkg::MODE_W-1:0]  timing_mode,
  output logic                         fire
);
  import rshs_pkg::*;

  logic [PHASE_W-1:0]  phase_accum;
  logic [SCALED_W-1:0] last_scaled_beat;
  logic                sync;
  logic [MODE_W-1:0]   mode_c;
  logic [SHIFT_W-1:0]  shift;
  logic [SCALED_W-1:0] scaled;
  logic [PHASE_W-1:0]  phase_sum;

  always_comb begin
    sync      = (timing_mode != '0) && transport_playing;
    mode_c    = (timing_mode > MODE_W'(MODE_MAX)) ? MODE_W'(MODE_MAX) : timing_mode;
    shift     = SHIFT_W'(SYNC_SHIFT_BASE) - {1'b0, mode_c};
    scaled    = SCALED_W'(beat_position >> shift);
    phase_sum = phase_accum + {1'b0, phase_step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum      <= {1'b1, {(PHASE_W-1){1'b0}}};
      last_scaled_beat <= '0;
      fire             <= 1'b0;
    end else if (accept) begin
      if (sync) begin
        // Store the scaled beat even when it moves backward.
        fire             <= scaled > last_scaled_beat;
        last_scaled_beat <= scaled;
      end else begin
        fire        <= phase_sum[PHASE_W-1];
        phase_accum <= {1'b0, phase_sum[PHASE_W-2:0]};
      end
    end
  end

endmodule

FILE: rtl/random_sample_hold_slew_unit.sv
// Top level: random sample-and-hold with slew, gate and trigger pulse.
// A word without a draw takes one 16-step bit-serial multiplier pass (slew);
// a word with a draw takes two (draw, then slew); the result word can wait on out_ch.ready.
// One word in flight at a time: a new word is accepted only in the idle state.
// Reset (synchronous, active high) loads the default registers, zero values,
// and a full phase so the first free-running tick draws.
`include "assert_macros.svh"

module random_sample_hold_slew_unit #(
  parameter int PULSE_SAMPLES = rshs_pkg::PULSE_SAMPLES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rshs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rshs_pkg::CFG_DATA_W-1:0]  cfg_data,
  rshs_in_if.sink                          in_ch,
  rshs_out_if.source                       out_ch
);
  import rshs_pkg::*;

  localparam int PULSE_W = $clog2(PULSE_SAMPLES + 1);
  localparam int ST_W    = 3;

  localparam logic [ST_W-1:0] S_IDLE = 3'd0;
  localparam logic [ST_W-1:0] S_PREP = 3'd1;
  localparam logic [ST_W-1:0] S_DRAW = 3'd2;
  localparam logic [ST_W-1:0] S_LOAD = 3'd3;
  localparam logic [ST_W-1:0] S_SLEW = 3'd4;
  localparam logic [ST_W-1:0] S_DONE = 3'd5;

  // Configuration registers
  raw_t              raw_low;
  raw_t              raw_high;
  cv_t               cv_low;
  cv_t               cv_high;
  cv_t               gate_threshold;
  cv_t               slew_coefficient;
  logic [STEP_W-1:0] phase_step;
  logic [MODE_W-1:0] timing_mode;

  // Value state
  raw_t               raw_target;
  raw_t               raw_current;
  cv_t                cv_target;
  cv_t                cv_current;
  logic [PULSE_W-1:0] pulse_left;

  // Per-word hold
  frac_t frac_raw;
  frac_t frac_cv;

  logic [ST_W-1:0] state;
  logic            accept;
  logic            ev_fire;
  logic            mul_start;
  logic            draw_sel;
  logic            mul_done_raw;
  logic            mul_done_cv;
  logic            mul_done;
  logic            out_load;

  logic signed [RAW_W:0]   raw_span;
  logic signed [RAW_W:0]   raw_delta;
  logic signed [RAW_W:0]   raw_mcand;
  logic signed [RAW_W+1:0] raw_hi;
  logic                    raw_rnd;
  logic signed [CV_W:0]    cv_span;
  logic signed [CV_W:0]    cv_delta;
  logic signed [CV_W:0]    cv_mcand;
  logic signed [CV_W+1:0]  cv_hi;
  logic                    cv_rnd;
  frac_t                   mplier_raw;
  frac_t                   mplier_cv;
  raw_t                    raw_draw;
  raw_t                    raw_slew;
  cv_t                     cv_draw;
  cv_t                     cv_slew;
  logic                    jump;
  logic                    jump_load;
  logic                    at_target;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Load the output register when a result is ready and the register is free.
  assign out_load = (state == S_DONE) && (!out_ch.valid || out_ch.ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_low          <= '0;
      raw_high         <= RAW_W'(65536);
      cv_low           <= '0;
      cv_high          <= CV_W'(65536);
      gate_threshold   <= CV_W'(32768);
      slew_coefficient <= CV_W'(65536);
      phase_step       <= STEP_W'(89478);
      timing_mode      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAW_LOW:     raw_low          <= cfg_data[RAW_W-1:0];
        REG_RAW_HIGH:    raw_high         <= cfg_data[RAW_W-1:0];
        REG_CV_LOW:      cv_low           <= cfg_data[CV_W-1:0];
        REG_CV_HIGH:     cv_high          <= cfg_data[CV_W-1:0];
        REG_GATE_THR:    gate_threshold   <= cfg_data[CV_W-1:0];
        REG_SLEW_COEF:   slew_coefficient <= cfg_data[CV_W-1:0];
        REG_PHASE_STEP:  phase_step       <= cfg_data[STEP_W-1:0];
        REG_TIMING_MODE: timing_mode      <= cfg_data[MODE_W-1:0];
      endcase
    end
  end

  // Event detection updates the phase or the beat state, by mode, on each accepted word.
  rshs_event u_event (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .transport_playing (in_ch.transport_playing),
    .beat_position     (in_ch.beat_position),
    .phase_step        (phase_step),
    .timing_mode       (timing_mode),
    .fire              (ev_fire)
  );

  // Multiplier operands: range span times fraction for a draw,
  // target minus current times coefficient for the slew.
  always_comb begin
    draw_sel   = (state == S_PREP) && ev_fire;
    mul_start  = (state == S_PREP) || (state == S_LOAD);
    raw_span   = {raw_high[RAW_W-1], raw_high} - {raw_low[RAW_W-1], raw_low};
    raw_delta  = {raw_target[RAW_W-1], raw_target} - {raw_current[RAW_W-1], raw_current};
    cv_span    = $signed({1'b0, cv_high}) - $signed({1'b0, cv_low});
    cv_delta   = $signed({1'b0, cv_target}) - $signed({1'b0, cv_current});
    raw_mcand  = draw_sel ? raw_span : raw_delta;
    cv_mcand   = draw_sel ? cv_span : cv_delta;
    mplier_raw = draw_sel ? frac_raw : slew_coefficient[FRAC_W-1:0];
    mplier_cv  = draw_sel ? frac_cv : slew_coefficient[FRAC_W-1:0];
  end

  rshs_serial_mul #(.W(RAW_W + 1)) u_mul_raw (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .mcand    (raw_mcand),
    .mplier   (mplier_raw),
    .done     (mul_done_raw),
    .prod_hi  (raw_hi),
    .prod_rnd (raw_rnd)
  );

  rshs_serial_mul #(.W(CV_W + 1)) u_mul_cv (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .mcand    (cv_mcand),
    .mplier   (mplier_cv),
    .done     (mul_done_cv),
    .prod_hi  (cv_hi),
    .prod_rnd (cv_rnd)
  );

  assign mul_done = mul_done_raw && mul_done_cv;

  // Results land inside their ranges, so the low bits carry the whole value.
  // Slew adds bit 15 of the product: rounding half up.
  always_comb begin
    jump      = slew_coefficient[CV_W-1];
    raw_draw  = raw_low + raw_hi[RAW_W-1:0];
    cv_draw   = cv_low + cv_hi[CV_W-1:0];
    raw_slew  = raw_current + raw_hi[RAW_W-1:0] + RAW_W'(raw_rnd);
    cv_slew   = cv_current + cv_hi[CV_W-1:0] + CV_W'(cv_rnd);
    jump_load = (state == S_SLEW) && mul_done && jump;
    at_target = (raw_current == raw_target) && (cv_current == cv_target);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      raw_target  <= '0;
      raw_current <= '0;
      cv_target   <= '0;
      cv_current  <= '0;
      pulse_left  <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (ev_fire) begin
            // Arm the pulse on the value from before this tick's slew.
            if (cv_current >= gate_threshold) begin
              pulse_left <= PULSE_W'(PULSE_SAMPLES);
            end
            state <= S_DRAW;
          end else begin
            state <= S_SLEW;
          end
        end
        S_DRAW: begin
          if (mul_done) begin
            raw_target <= raw_draw;
            cv_target  <= cv_draw;
            state      <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_SLEW;
        end
        S_SLEW: begin
          if (mul_done) begin
            raw_current <= jump ? raw_target : raw_slew;
            cv_current  <= jump ? cv_target : cv_slew;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (out_load) begin
            if (pulse_left != '0) begin
              pulse_left <= pulse_left - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.raw_value <= raw_current;
      out_ch.cv_value  <= cv_current;
      out_ch.gate      <= cv_current >= gate_threshold;
      out_ch.trigger   <= pulse_left != '0;
    end
  end

  // Hold word-level fractions for the draw.
  always_ff @(posedge clk) begin
    if (accept) begin
      frac_raw <= in_ch.random_raw;
      frac_cv  <= in_ch.random_cv;
    end
  end

  `ASSERT_IMPLIES(a_mul_lanes_aligned, clk, rst, mul_done_raw || mul_done_cv, mul_done)
  `ASSERT_IMPLIES(a_mul_done_in_wait, clk, rst, mul_done, (state == S_DRAW) || (state == S_SLEW))
  `ASSERT_NEXT(a_jump_reaches_target, clk, rst, jump_load, at_target)
  `ASSERT_IMPLIES(a_pulse_bounded, clk, rst, 1'b1, pulse_left <= PULSE_W'(PULSE_SAMPLES))

endmodule
